// File: rtl/quadrature_pid_position_servo_assert.svh
// ----------------------------------------------------------------------------
// quadrature pid position servo assertion macros
// checks written in the top level through these macros
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_PID_POSITION_SERVO_ASSERT_SVH
`define QUADRATURE_PID_POSITION_SERVO_ASSERT_SVH

// property must hold at every clock edge out of reset
`define QPS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression must never be true out of reset
`define QPS_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// File: rtl/qps_pkg.sv
// ----------------------------------------------------------------------------
// qps_pkg
// shared constants for the quadrature pid position servo
// ----------------------------------------------------------------------------
package qps_pkg;

    localparam int GEAR_RATIO = 216;
    localparam int PWM_MAX    = 255;
    localparam int DRIVE_MAX  = (PWM_MAX < 255) ? PWM_MAX : 255;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd3;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 48;

    localparam logic [47:0] ITAE_MAX = 48'hFFFF_FFFF_FFFF;

endpackage

// File: rtl/qps_req_if.sv
// ----------------------------------------------------------------------------
// qps_req_if
// request word channel: encoder edge or control tick
// ----------------------------------------------------------------------------
interface qps_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        edge_channel;
    logic        level_a;
    logic        level_b;
    logic [15:0] tick_ms;

    modport source (output valid, req_type, edge_channel, level_a, level_b, tick_ms,
                    input ready);
    modport sink (input valid, req_type, edge_channel, level_a, level_b, tick_ms,
                  output ready);
endinterface

// File: rtl/qps_res_if.sv
// ----------------------------------------------------------------------------
// qps_res_if
// result word channel: drive, position and score
// ----------------------------------------------------------------------------
interface qps_res_if;
    logic               valid;
    logic               ready;
    logic [7:0]         drive_level;
    logic               drive_reverse;
    logic signed [31:0] position_count;
    logic signed [31:0] position_error;
    logic [47:0]        itae_score;

    modport source (output valid, drive_level, drive_reverse, position_count,
                    position_error, itae_score, input ready);
    modport sink (input valid, drive_level, drive_reverse, position_count,
                  position_error, itae_score, output ready);
endinterface

// File: rtl/quadrature_pid_position_servo.sv
// edge result: an encoder edge word's result is registered and shown in the cycle after acceptance
// tick result: a control tick's result follows two
//   48-step serial divides and six 32-step serial shift-add multiplies, with a state
//   hop after each
// throughput: one word at a time; the next is taken once the result slot is free
// reset: synchronous active low, clears count, pid state, score and registers
// ----------------------------------------------------------------------------
// quadrature_pid_position_servo
// x4 quadrature counter with a bit-serial pid position loop and itae score
// ----------------------------------------------------------------------------
`include "quadrature_pid_position_servo_assert.svh"

module quadrature_pid_position_servo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [qps_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [qps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    qps_req_if.sink                          i_req,
    qps_res_if.source                        o_res
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_GDIV = 4'd1;
    localparam logic [3:0] ST_MINT = 4'd2;
    localparam logic [3:0] ST_MP   = 4'd3;
    localparam logic [3:0] ST_MI   = 4'd4;
    localparam logic [3:0] ST_MD   = 4'd5;
    localparam logic [3:0] ST_DDIV = 4'd6;
    localparam logic [3:0] ST_MA   = 4'd7;
    localparam logic [3:0] ST_MB   = 4'd8;

    logic [3:0]         r_state;
    logic               r_ov;
    logic [7:0]         r_lvl;
    logic               r_rev;

    logic signed [23:0] r_gp, r_gi, r_gd;
    logic signed [31:0] r_tgt;
    logic [31:0]        r_cnt;
    logic signed [31:0] r_prev;
    logic signed [47:0] r_int;
    logic [31:0]        r_rt;
    logic [47:0]        r_itae;

    logic [15:0]        r_dt;
    logic signed [31:0] r_e;
    logic signed [57:0] r_u;

    // serial multiplier
    logic [63:0]        r_mc;
    logic [31:0]        r_mp;
    logic [95:0]        r_acc;
    logic               r_msg;
    logic [4:0]         r_mcnt;
    logic               r_mbusy;

    // serial divider
    logic [47:0]        r_dvd;
    logic [15:0]        r_rem;
    logic [15:0]        r_dvs;
    logic               r_dsg;
    logic [5:0]         r_dcnt;
    logic               r_dbusy;

    logic               w_acc_in;
    logic               w_set_ov;
    logic               w_up;
    logic [64:0]        w_sum;
    logic [16:0]        w_rsh;
    logic               w_ge;
    logic [15:0]        n_rem;
    logic [16:0]        w_rsub;
    logic signed [48:0] w_q49;
    logic [49:0]        w_ediff;
    logic signed [31:0] n_e;
    logic signed [72:0] w_ps;
    logic signed [56:0] w_pfl;
    logic [49:0]        w_isum;
    logic signed [47:0] n_int;
    logic signed [32:0] w_de;
    logic [32:0]        w_de_abs;
    logic [31:0]        w_e_abs;
    logic [47:0]        w_int_abs;
    logic [23:0]        w_gp_abs, w_gi_abs, w_gd_abs;
    logic [56:0]        w_f_abs;
    logic signed [57:0] w_uf;
    logic signed [57:0] w_v;
    logic signed [41:0] w_m;
    logic [7:0]         n_lvl;
    logic [47:0]        w_add;
    logic [48:0]        w_isat;
    logic [32:0]        w_rt33;
    logic [15:0]        w_dt_div;
    logic               w_e_pos;

    assign w_acc_in    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE) && (!r_ov || o_res.ready);
    assign w_up        = i_req.edge_channel ? (i_req.level_a == i_req.level_b)
                                            : (i_req.level_a != i_req.level_b);
    assign w_set_ov    = (w_acc_in && (i_req.req_type == qps_pkg::REQ_EDGE))
                      || ((r_state == ST_MB) && !r_mbusy);

    assign o_res.valid          = r_ov;
    assign o_res.drive_level    = r_lvl;
    assign o_res.drive_reverse  = r_rev;
    assign o_res.position_count = r_cnt;
    assign o_res.position_error = r_prev;
    assign o_res.itae_score     = r_itae;

    // datapath steps
    always_comb begin
        w_sum  = {1'b0, r_acc[95:32]} + (r_mp[0] ? {1'b0, r_mc} : 65'd0);
        w_rsh  = {r_rem, r_dvd[47]};
        w_rsub = w_rsh - {1'b0, r_dvs};
        w_ge   = (w_rsh >= {1'b0, r_dvs});
        n_rem  = w_ge ? w_rsub[15:0] : w_rsh[15:0];

        w_q49   = r_dsg ? -$signed({1'b0, r_dvd}) : $signed({1'b0, r_dvd});
        w_ediff = {{18{r_tgt[31]}}, r_tgt} - {w_q49[48], w_q49};
        if ((w_ediff[49:31] == '0) || (&w_ediff[49:31])) begin
            n_e = w_ediff[31:0];
        end else begin
            n_e = w_ediff[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end

        w_ps  = r_msg ? -$signed({1'b0, r_acc[71:0]}) : $signed({1'b0, r_acc[71:0]});
        w_pfl = w_ps[72:16];

        w_isum = {{2{r_int[47]}}, r_int} + w_ps[49:0];
        if ((w_isum[49:47] == '0) || (&w_isum[49:47])) begin
            n_int = w_isum[47:0];
        end else begin
            n_int = w_isum[49] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end

        w_de      = {r_e[31], r_e} - {r_prev[31], r_prev};
        w_de_abs  = w_de[32] ? -w_de : w_de;
        w_e_abs   = r_e[31] ? -r_e : r_e;
        w_int_abs = r_int[47] ? -r_int : r_int;
        w_gp_abs  = r_gp[23] ? -r_gp : r_gp;
        w_gi_abs  = r_gi[23] ? -r_gi : r_gi;
        w_gd_abs  = r_gd[23] ? -r_gd : r_gd;
        w_f_abs   = w_pfl[56] ? -w_pfl : w_pfl;

        w_uf    = r_u + {{9{w_q49[48]}}, w_q49};
        w_e_pos = !r_e[31] && (|r_e);
        w_v     = w_e_pos ? w_uf : -w_uf;
        w_m     = w_v[57:16];
        if (w_m[41]) begin
            n_lvl = 8'd0;
        end else if (w_m[40:0] > 41'(qps_pkg::DRIVE_MAX)) begin
            n_lvl = 8'(qps_pkg::DRIVE_MAX);
        end else begin
            n_lvl = w_m[7:0];
        end

        w_add  = (|r_acc[95:48]) ? qps_pkg::ITAE_MAX : r_acc[47:0];
        w_isat = {1'b0, r_itae} + {1'b0, w_add};

        w_rt33   = {1'b0, r_rt} + {17'd0, i_req.tick_ms};
        w_dt_div = (r_dt == 16'd0) ? 16'd1 : r_dt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_mbusy <= 1'b0;
            r_dbusy <= 1'b0;
            r_gp    <= '0;
            r_gi    <= '0;
            r_gd    <= '0;
            r_tgt   <= '0;
            r_cnt   <= '0;
            r_prev  <= '0;
            r_int   <= '0;
            r_rt    <= '0;
            r_itae  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    qps_pkg::REG_GAIN_P: r_gp  <= i_cfg_data[23:0];
                    qps_pkg::REG_GAIN_I: r_gi  <= i_cfg_data[23:0];
                    qps_pkg::REG_GAIN_D: r_gd  <= i_cfg_data[23:0];
                    qps_pkg::REG_TARGET: r_tgt <= i_cfg_data[31:0];
                    default: ;
                endcase
            end

            if (o_res.ready && !w_set_ov) begin
                r_ov <= 1'b0;
            end

            if (r_mbusy) begin
                r_acc  <= {w_sum, r_acc[31:1]};
                r_mp   <= {1'b0, r_mp[31:1]};
                r_mcnt <= r_mcnt + 5'd1;
                if (r_mcnt == 5'(qps_pkg::MUL_STEPS - 1)) begin
                    r_mbusy <= 1'b0;
                end
            end

            if (r_dbusy) begin
                r_rem  <= n_rem;
                r_dvd  <= {r_dvd[46:0], w_ge};
                r_dcnt <= r_dcnt + 6'd1;
                if (r_dcnt == 6'(qps_pkg::DIV_STEPS - 1)) begin
                    r_dbusy <= 1'b0;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_acc_in) begin
                        if (i_req.req_type == qps_pkg::REQ_EDGE) begin
                            r_cnt <= w_up ? r_cnt + 32'd1 : r_cnt - 32'd1;
                            r_lvl <= 8'd0;
                            r_rev <= 1'b0;
                            r_ov  <= 1'b1;
                        end else begin
                            r_dt    <= i_req.tick_ms;
                            r_rt    <= w_rt33[32] ? 32'hFFFF_FFFF : w_rt33[31:0];
                            r_dvd   <= r_cnt[31] ? {-r_cnt, 16'd0} : {r_cnt, 16'd0};
                            r_dsg   <= r_cnt[31];
                            r_dvs   <= 16'(qps_pkg::GEAR_RATIO);
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_dbusy <= 1'b1;
                            r_state <= ST_GDIV;
                        end
                    end
                end
                ST_GDIV: begin
                    if (!r_dbusy) begin
                        r_e     <= n_e;
                        r_acc   <= '0;
                        r_mc    <= {32'd0, n_e[31] ? -n_e : n_e};
                        r_mp    <= {16'd0, r_dt};
                        r_msg   <= n_e[31];
                        r_mcnt  <= '0;
                        r_mbusy <= 1'b1;
                        r_state <= ST_MINT;
                    end
                end
                ST_MINT: begin
                    if (!r_mbusy) begin
                        r_int   <= n_int;
                        r_acc   <= '0;
                        r_mc    <= {32'd0, w_e_abs};
                        r_mp    <= {8'd0, w_gp_abs};
                        r_msg   <= r_e[31] ^ r_gp[23];
                        r_mcnt  <= '0;
                        r_mbusy <= 1'b1;
                        r_state <= ST_MP;
                    end
                end
                ST_MP: begin
                    if (!r_mbusy) begin
                        r_u     <= {w_pfl[56], w_pfl};
                        r_acc   <= '0;
                        r_mc    <= {16'd0, w_int_abs};
                        r_mp    <= {8'd0, w_gi_abs};
                        r_msg   <= r_int[47] ^ r_gi[23];
                        r_mcnt  <= '0;
                        r_mbusy <= 1'b1;
                        r_state <= ST_MI;
                    end
                end
                ST_MI: begin
                    if (!r_mbusy) begin
                        r_u     <= r_u + {w_pfl[56], w_pfl};
                        r_acc   <= '0;
                        r_mc    <= {31'd0, w_de_abs};
                        r_mp    <= {8'd0, w_gd_abs};
                        r_msg   <= w_de[32] ^ r_gd[23];
                        r_mcnt  <= '0;
                        r_mbusy <= 1'b1;
                        r_state <= ST_MD;
                    end
                end
                ST_MD: begin
                    if (!r_mbusy) begin
                        r_dvd   <= w_f_abs[47:0];
                        r_dsg   <= w_pfl[56];
                        r_dvs   <= w_dt_div;
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_dbusy <= 1'b1;
                        r_state <= ST_DDIV;
                    end
                end
                ST_DDIV: begin
                    if (!r_dbusy) begin
                        r_lvl   <= n_lvl;
                        r_rev   <= !w_e_pos;
                        r_acc   <= '0;
                        r_mc    <= {32'd0, w_e_abs};
                        r_mp    <= r_rt;
                        r_msg   <= 1'b0;
                        r_mcnt  <= '0;
                        r_mbusy <= 1'b1;
                        r_state <= ST_MA;
                    end
                end
                ST_MA: begin
                    if (!r_mbusy) begin
                        r_acc   <= '0;
                        r_mc    <= r_acc[63:0];
                        r_mp    <= {16'd0, r_dt};
                        r_mcnt  <= '0;
                        r_mbusy <= 1'b1;
                        r_state <= ST_MB;
                    end
                end
                ST_MB: begin
                    if (!r_mbusy) begin
                        r_itae  <= w_isat[48] ? qps_pkg::ITAE_MAX : w_isat[47:0];
                        r_prev  <= r_e;
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    `QPS_CHECK(a_tick_starts_div, (w_acc_in && i_req.req_type == qps_pkg::REQ_TICK) |=> (r_state == ST_GDIV), "tick word did not start the gear divide")
    `QPS_CHECK(a_edge_result, (w_acc_in && i_req.req_type == qps_pkg::REQ_EDGE) |=> (r_ov && r_lvl == 8'd0 && !r_rev), "edge word result missing or drive not zero")
    `QPS_NEVER(a_units_exclusive, r_mbusy && r_dbusy, "multiplier and divider busy together")

endmodule
